### sv/ffrp_pkg.sv
// Shared types and constants for the first-fit resource placer.
package ffrp_pkg;

    localparam int MACHINES_DEF = 256;
    localparam int INDEX_LIMIT  = 256;

    localparam int AMT_W = 17;
    localparam int MID_W = 8;
    localparam int CNT_W = 9;
    localparam int ST_W  = 2;

    localparam logic [AMT_W-1:0] FULL_CAP = 17'h10000;

    localparam logic FUNC_PLACE   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [ST_W-1:0] ST_PLACED   = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [ST_W-1:0] ST_RELEASED = 2'd2;

    // Request token that walks the cell row.
    typedef struct packed {
        logic             valid;
        logic             func;
        logic [AMT_W-1:0] cpu;
        logic [AMT_W-1:0] mem;
        logic [AMT_W-1:0] disk;
        logic [MID_W-1:0] mid;
        logic             placed;
        logic [MID_W-1:0] idx;
    } tok_t;

endpackage

### sv/first_fit_resource_placer_top.sv
// A beat passes every cell register, then the result register; CELLS = min(MACHINES, 256).
// Throughput: one beat per cycle unless stalled; a request steps one machine cell per cycle,
// and the first in-use cell that fits takes the request, so later requests see its update.
// A stalled result freezes the whole cell row and the input side.
// Reset (synchronous, aresetn low): every machine full, machines_in_use 256, no beats held.
module first_fit_resource_placer_top #(
    parameter int MACHINES = ffrp_pkg::MACHINES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,     // machines_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // disk_request[16:0], mem_request[33:17],
                                       // cpu_request[50:34], machine_id[58:51], zero fill
    input  logic        s_tuser,       // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // machine_index
    output logic [1:0]  m_tuser        // status
);

    localparam int CELLS = (MACHINES < ffrp_pkg::INDEX_LIMIT) ? MACHINES
                                                              : ffrp_pkg::INDEX_LIMIT;

    logic [ffrp_pkg::CNT_W-1:0] in_use_reg;
    logic                       advance;
    ffrp_pkg::tok_t             chain [CELLS+1];

    logic                       m_valid_reg;
    logic [ffrp_pkg::MID_W-1:0] m_idx_reg, m_idx_next;
    logic [ffrp_pkg::ST_W-1:0]  m_st_reg, m_st_next;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= ffrp_pkg::CNT_W'(ffrp_pkg::INDEX_LIMIT);
        end else if (cfg_we) begin
            in_use_reg <= cfg_wdata;
        end
    end

    // valid, func, cpu, mem, disk, mid, placed, idx
    assign chain[0] = {s_tvalid, s_tuser, s_tdata[50:34], s_tdata[33:17], s_tdata[16:0],
                       s_tdata[58:51], 1'b0, {ffrp_pkg::MID_W{1'b0}}};

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        ffrp_cell #(
            .CELL_ID(g)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .advance(advance),
            .in_use (in_use_reg),
            .tok_in (chain[g]),
            .tok_out(chain[g+1])
        );
    end

    always_comb begin
        if (chain[CELLS].func == ffrp_pkg::FUNC_RELEASE) begin
            m_st_next  = ffrp_pkg::ST_RELEASED;
            m_idx_next = chain[CELLS].mid;
        end else if (chain[CELLS].placed) begin
            m_st_next  = ffrp_pkg::ST_PLACED;
            m_idx_next = chain[CELLS].idx;
        end else begin
            m_st_next  = ffrp_pkg::ST_NOFIT;
            m_idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= chain[CELLS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_st_reg  <= m_st_next;
            m_idx_reg <= m_idx_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_idx_reg;
    assign m_tuser  = m_st_reg;

endmodule

### sv/ffrp_cell.sv
// One machine's free capacity and its stage of the request chain.
module ffrp_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic [ffrp_pkg::CNT_W-1:0] in_use,
    input  ffrp_pkg::tok_t             tok_in,
    output ffrp_pkg::tok_t             tok_out
);

    localparam logic [ffrp_pkg::CNT_W-1:0] ID_CNT = ffrp_pkg::CNT_W'(CELL_ID);
    localparam logic [ffrp_pkg::MID_W-1:0] ID_MID = ffrp_pkg::MID_W'(CELL_ID);

    logic [ffrp_pkg::AMT_W-1:0] cpu_reg, cpu_next;
    logic [ffrp_pkg::AMT_W-1:0] mem_reg, mem_next;
    logic [ffrp_pkg::AMT_W-1:0] disk_reg, disk_next;
    ffrp_pkg::tok_t             tok_reg, tok_next;

    logic                       fits;
    logic                       take;
    logic                       rel_hit;
    logic [ffrp_pkg::AMT_W:0]   cpu_sum, mem_sum, disk_sum;

    assign fits = (tok_in.cpu <= cpu_reg) && (tok_in.mem <= mem_reg)
               && (tok_in.disk <= disk_reg);
    assign take = tok_in.valid && (tok_in.func == ffrp_pkg::FUNC_PLACE)
               && !tok_in.placed && (ID_CNT < in_use) && fits;
    assign rel_hit = tok_in.valid && (tok_in.func == ffrp_pkg::FUNC_RELEASE)
                  && (tok_in.mid == ID_MID);

    assign cpu_sum  = {1'b0, cpu_reg} + {1'b0, tok_in.cpu};
    assign mem_sum  = {1'b0, mem_reg} + {1'b0, tok_in.mem};
    assign disk_sum = {1'b0, disk_reg} + {1'b0, tok_in.disk};

    always_comb begin
        cpu_next  = cpu_reg;
        mem_next  = mem_reg;
        disk_next = disk_reg;
        tok_next  = tok_in;
        if (take) begin
            cpu_next        = cpu_reg - tok_in.cpu;
            mem_next        = mem_reg - tok_in.mem;
            disk_next       = disk_reg - tok_in.disk;
            tok_next.placed = 1'b1;
            tok_next.idx    = ID_MID;
        end else if (rel_hit) begin
            // saturate at a full machine
            cpu_next  = (cpu_sum > {1'b0, ffrp_pkg::FULL_CAP})
                      ? ffrp_pkg::FULL_CAP : cpu_sum[ffrp_pkg::AMT_W-1:0];
            mem_next  = (mem_sum > {1'b0, ffrp_pkg::FULL_CAP})
                      ? ffrp_pkg::FULL_CAP : mem_sum[ffrp_pkg::AMT_W-1:0];
            disk_next = (disk_sum > {1'b0, ffrp_pkg::FULL_CAP})
                      ? ffrp_pkg::FULL_CAP : disk_sum[ffrp_pkg::AMT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_reg  <= ffrp_pkg::FULL_CAP;
            mem_reg  <= ffrp_pkg::FULL_CAP;
            disk_reg <= ffrp_pkg::FULL_CAP;
            tok_reg  <= '0;
        end else if (advance) begin
            cpu_reg  <= cpu_next;
            mem_reg  <= mem_next;
            disk_reg <= disk_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
